FILE: rtl/core/daily_schedule_level_interpolator_macros.svh
// Assertion macros for the schedule level interpolator.
// Included by daily_schedule_level_interpolator, which checks its own logic; no other dependencies.
`ifndef DAILY_SCHEDULE_LEVEL_INTERPOLATOR_MACROS_SVH
`define DAILY_SCHEDULE_LEVEL_INTERPOLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSLI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dsli assertion failed");
`define DSLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dsli assertion failed");
`else
`define DSLI_ASSERT(lbl, clk, rstn, prop)
`define DSLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/dsli_pkg.sv
// Shared constants, codes and types of the schedule level interpolator.
// No dependencies.
package dsli_pkg;

  localparam int unsigned POINTS_DEF    = 8;
  localparam int unsigned LEVEL_MAX_DEF = 1023;
  localparam int unsigned DAY_MINUTES   = 1440;
  localparam int unsigned MIN_W         = 11;
  localparam int unsigned LVL_W         = 16;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_MODE   = 2'd1;
  localparam logic [1:0] KIND_MANUAL = 2'd2;
  localparam logic [1:0] KIND_POINT  = 2'd3;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_SCHED  = 2'd2;

  typedef struct packed {
    logic             active;
    logic [MIN_W-1:0] minute;
    logic [LVL_W-1:0] level;
  } point_t;

endpackage

FILE: rtl/core/daily_schedule_level_interpolator.sv
// Items that need no table scan (tick, mode, manual, point) pass from accept through EXEC
// to DONE. A scheduled update scans one slot per cycle, then goes through DRAIN and MUL;
// where a division is needed, a serial divide (DIV) and FIN follow before DONE.
// One item at a time: the next item is taken in the cycle after the result is registered,
// even if not yet drained. Reset (async, active low): mode off, levels zero, slots inactive.
// Depends on dsli_pkg, dsli_point_table, dsli_divider and the assertion macro header.
`include "daily_schedule_level_interpolator_macros.svh"
module daily_schedule_level_interpolator import dsli_pkg::*; #(
  parameter int unsigned POINTS    = POINTS_DEF,
  parameter int unsigned LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // minute_of_day[10:0], time_valid[11], mode[13:12], level[29:14],
  // point_index[32:30], point_minute[43:33], point_deleted[44], zero[47:45]
  input  logic [47:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // accepted[0], drive_level[16:1], drive_changed[17], requested_level[33:18],
  // has_points[34], clock_ok[35], mode_now[37:36], zero[39:38]
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned AW   = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned NW   = 27;
  localparam logic [LVL_W-1:0] LvlMax = LVL_W'(LEVEL_MAX);
  localparam logic [MIN_W-1:0] DayMin = MIN_W'(DAY_MINUTES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [1:0]       it_kind_q;
  logic [MIN_W-1:0] it_minute_q;
  logic             it_tok_q;
  logic [1:0]       it_mode_q;
  logic [LVL_W-1:0] it_level_q;
  logic [2:0]       it_idx_q;
  logic [MIN_W-1:0] it_pmin_q;
  logic             it_pdel_q;

  logic [1:0]       mode_q, mode_d;
  logic [LVL_W-1:0] manual_q, manual_d;
  logic [LVL_W-1:0] sched_q, sched_d;
  logic [LVL_W-1:0] driven_q, driven_d;
  logic             clkok_q, clkok_d;
  logic             acc_q, acc_d;
  logic             chg_q, chg_d;

  logic [AW-1:0]    cnt_q, cnt_d;
  logic             rdv_q, rdv_d;
  logic [MIN_W-1:0] pd_q, pd_d, nd_q, nd_d;
  logic [LVL_W-1:0] plvl_q, plvl_d, nlvl_q, nlvl_d;
  logic [1:0]       npts_q, npts_d;
  logic [NW-1:0]    num;
  logic             neg_q, neg_d;

  logic             m_valid_q, m_valid_d;
  logic [39:0]      out_q, out_d;

  logic             accept;
  logic             wr_en;
  point_t           wr_entry;
  point_t           rd_entry;
  logic             has_points;
  logic             div_start, div_done;
  logic [NW-1:0]    div_quo;
  logic             drv_en;
  logic [LVL_W-1:0] drv_val;
  logic             upd;
  logic [MIN_W:0]   m_ext, p_ext, back, fwd;
  logic [MIN_W:0]   span_sum;
  logic [LVL_W-1:0] mag;
  logic [LVL_W+1:0] res;
  logic [LVL_W-1:0] req_lvl;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign span_sum        = {1'b0, pd_q} + {1'b0, nd_q};

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    manual_d  = manual_q;
    sched_d   = sched_q;
    driven_d  = driven_q;
    clkok_d   = clkok_q;
    acc_d     = acc_q;
    chg_d     = chg_q;
    cnt_d     = cnt_q;
    rdv_d     = rdv_q;
    pd_d      = pd_q;
    nd_d      = nd_q;
    plvl_d    = plvl_q;
    nlvl_d    = nlvl_q;
    npts_d    = npts_q;
    num       = '0;
    neg_d     = neg_q;
    m_valid_d = m_valid_q;
    out_d     = out_q;
    wr_en     = 1'b0;
    div_start = 1'b0;
    drv_en    = 1'b0;
    drv_val   = '0;
    upd       = 1'b0;
    mag       = '0;
    res       = '0;
    req_lvl   = '0;
    m_ext     = {1'b0, it_minute_q};
    p_ext     = {1'b0, rd_entry.minute};
    back      = (m_ext >= p_ext) ? (m_ext - p_ext) : (m_ext + {1'b0, DayMin} - p_ext);
    fwd       = (p_ext >= m_ext) ? (p_ext - m_ext) : (p_ext + {1'b0, DayMin} - m_ext);

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_d   = 1'b1;
          chg_d   = 1'b0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (it_kind_q)
          KIND_TICK: begin
            if (mode_q == MODE_OFF) begin
              drv_en = 1'b1;
            end else if (mode_q == MODE_SCHED) begin
              upd = 1'b1;
            end
          end
          KIND_MODE: begin
            case (it_mode_q)
              MODE_OFF: begin
                mode_d = MODE_OFF;
                drv_en = 1'b1;
              end
              MODE_MANUAL: begin
                manual_d = driven_q;
                mode_d   = MODE_MANUAL;
              end
              MODE_SCHED: begin
                mode_d = MODE_SCHED;
                upd    = 1'b1;
              end
              default: acc_d = 1'b0;
            endcase
          end
          KIND_MANUAL: begin
            if (it_level_q > LvlMax) begin
              acc_d = 1'b0;
            end else begin
              manual_d = it_level_q;
              mode_d   = MODE_MANUAL;
              drv_en   = 1'b1;
              drv_val  = it_level_q;
            end
          end
          default: begin
            if ((32'(it_idx_q) >= POINTS) || (it_pmin_q >= DayMin) ||
                (it_level_q > LvlMax)) begin
              acc_d = 1'b0;
            end else begin
              wr_en = 1'b1;
              if (mode_q == MODE_SCHED) begin
                upd = 1'b1;
              end
            end
          end
        endcase
        state_d = ST_DONE;
        if (upd) begin
          clkok_d = it_tok_q && (it_minute_q < DayMin);
          if (clkok_d) begin
            cnt_d   = '0;
            rdv_d   = 1'b0;
            pd_d    = DayMin;
            nd_d    = DayMin;
            npts_d  = '0;
            state_d = ST_SCAN;
          end else begin
            sched_d = '0;
            drv_en  = 1'b1;
          end
        end
      end
      ST_SCAN, ST_DRAIN: begin
        if (rdv_q && rd_entry.active) begin
          if (npts_q != 2'd2) begin
            npts_d = npts_q + 1'b1;
          end
          if (back[MIN_W-1:0] < pd_q) begin
            pd_d   = back[MIN_W-1:0];
            plvl_d = rd_entry.level;
          end
          if (fwd[MIN_W-1:0] < nd_q) begin
            nd_d   = fwd[MIN_W-1:0];
            nlvl_d = rd_entry.level;
          end
        end
        if (state_q == ST_SCAN) begin
          rdv_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == AW'(POINTS - 1)) begin
            state_d = ST_DRAIN;
          end
        end else begin
          rdv_d   = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (npts_q == 2'd0) begin
          sched_d = '0;
          drv_en  = 1'b1;
          state_d = ST_DONE;
        end else if ((npts_q == 2'd1) || (span_sum == '0)) begin
          sched_d = plvl_q;
          drv_en  = 1'b1;
          drv_val = plvl_q;
          state_d = ST_DONE;
        end else begin
          neg_d     = (nlvl_q < plvl_q);
          mag       = neg_d ? (plvl_q - nlvl_q) : (nlvl_q - plvl_q);
          num       = NW'(mag * pd_q) + NW'(span_sum[MIN_W:1]);
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res = neg_q ? ({2'b00, plvl_q} - {2'b00, div_quo[LVL_W-1:0]})
                    : ({2'b00, plvl_q} + {2'b00, div_quo[LVL_W-1:0]});
        if (res[LVL_W+1]) begin
          sched_d = '0;
        end else if (res > {2'b00, LvlMax}) begin
          sched_d = LvlMax;
        end else begin
          sched_d = res[LVL_W-1:0];
        end
        drv_en  = 1'b1;
        drv_val = sched_d;
        state_d = ST_DONE;
      end
      default: begin
        if (!m_valid_q || m_axis_tready_i) begin
          case (mode_q)
            MODE_OFF:    req_lvl = '0;
            MODE_MANUAL: req_lvl = manual_q;
            default:     req_lvl = sched_q;
          endcase
          out_d     = {2'b00, mode_q, clkok_q, has_points, req_lvl, chg_q, driven_q, acc_q};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
    endcase

    if (drv_en && (driven_q != drv_val)) begin
      driven_d = drv_val;
      chg_d    = 1'b1;
    end
  end

  assign wr_entry = '{active: !it_pdel_q, minute: it_pmin_q, level: it_level_q};

  dsli_point_table #(
    .POINTS (POINTS),
    .AW     (AW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_addr_i    (AW'(it_idx_q)),
    .wr_entry_i   (wr_entry),
    .rd_addr_i    (cnt_q),
    .rd_entry_o   (rd_entry),
    .has_points_o (has_points)
  );

  dsli_divider #(
    .NW (NW),
    .DW (MIN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (span_sum[MIN_W-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_OFF;
      manual_q  <= '0;
      sched_q   <= '0;
      driven_q  <= '0;
      clkok_q   <= 1'b0;
      acc_q     <= 1'b0;
      chg_q     <= 1'b0;
      cnt_q     <= '0;
      rdv_q     <= 1'b0;
      npts_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      manual_q  <= manual_d;
      sched_q   <= sched_d;
      driven_q  <= driven_d;
      clkok_q   <= clkok_d;
      acc_q     <= acc_d;
      chg_q     <= chg_d;
      cnt_q     <= cnt_d;
      rdv_q     <= rdv_d;
      npts_q    <= npts_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_minute_q <= s_axis_tdata_i[10:0];
      it_tok_q    <= s_axis_tdata_i[11];
      it_mode_q   <= s_axis_tdata_i[13:12];
      it_level_q  <= s_axis_tdata_i[29:14];
      it_idx_q    <= s_axis_tdata_i[32:30];
      it_pmin_q   <= s_axis_tdata_i[43:33];
      it_pdel_q   <= s_axis_tdata_i[44];
      it_kind_q   <= s_axis_tuser_i;
    end
    pd_q   <= pd_d;
    nd_q   <= nd_d;
    plvl_q <= plvl_d;
    nlvl_q <= nlvl_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  `DSLI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !s_axis_tready_o)
  `DSLI_ASSERT(a_drive_in_range, clk_i, rst_ni, driven_q <= LvlMax)
  `DSLI_ASSERT(a_off_drives_zero, clk_i, rst_ni, (state_q == ST_IDLE && mode_q == MODE_OFF) |-> driven_q == '0)
  `DSLI_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_done |-> state_q == ST_DIV)

endmodule

FILE: rtl/core/dsli_point_table.sv
// Schedule point table: minute/level memory plus per-slot active flags.
// Depends on dsli_pkg.
module dsli_point_table import dsli_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEF,
  parameter int unsigned AW     = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  point_t        wr_entry_i,
  input  logic [AW-1:0] rd_addr_i,
  output point_t        rd_entry_o,
  output logic          has_points_o
);

  logic [MIN_W-1:0] minute_mem [POINTS];
  logic [LVL_W-1:0] level_mem  [POINTS];
  logic [POINTS-1:0] active_q;
  logic [MIN_W-1:0] rd_minute_q;
  logic [LVL_W-1:0] rd_level_q;
  logic             rd_active_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      minute_mem[wr_addr_i] <= wr_entry_i.minute;
      level_mem[wr_addr_i]  <= wr_entry_i.level;
    end
    rd_minute_q <= minute_mem[rd_addr_i];
    rd_level_q  <= level_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      rd_active_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        active_q[wr_addr_i] <= wr_entry_i.active;
      end
      rd_active_q <= active_q[rd_addr_i];
    end
  end

  assign rd_entry_o   = '{active: rd_active_q, minute: rd_minute_q, level: rd_level_q};
  assign has_points_o = |active_q;

endmodule

FILE: rtl/core/dsli_divider.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on dsli_pkg for the default of DW (MIN_W).
module dsli_divider import dsli_pkg::*; #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = MIN_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[DW+1]) begin
        rem_d = trial[DW:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: dv/tb_daily_schedule_level_interpolator.sv
// Testbench for daily_schedule_level_interpolator: directed and random items on the input
// stream, each result checked field by field against a built-in predictor of the block.
// Depends on dsli_pkg and the RTL of the block.
module tb_daily_schedule_level_interpolator;
  import dsli_pkg::*;

  typedef struct packed {
    logic             pdel;
    logic [MIN_W-1:0] pmin;
    logic [2:0]       idx;
    logic [LVL_W-1:0] level;
    logic [1:0]       mode;
    logic             valid;
    logic [MIN_W-1:0] minute;
  } cmd_fields_t;

  typedef struct packed {
    logic        drain;
    logic [1:0]  kind;
    cmd_fields_t f;
  } pending_item_t;

  typedef struct packed {
    logic [1:0]       mode_now;
    logic             clock_ok;
    logic             has_points;
    logic [LVL_W-1:0] requested_level;
    logic             drive_changed;
    logic [LVL_W-1:0] drive_level;
    logic             accepted;
  } level_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [47:0] in_data;
  logic [1:0]  in_kind;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [39:0] out_data;

  pending_item_t cur_item = '0;
  pending_item_t cmd_queue[$];
  level_result_t level_expect[$];
  bit            in_taken = 1'b0;
  int unsigned   sent_count = 0;
  int unsigned   total_items = 0;
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 19;
  int unsigned   recv_idle_pct = 47;

  // predictor state
  logic [MIN_W-1:0] tbl_minute [POINTS_DEF];
  logic [LVL_W-1:0] tbl_level  [POINTS_DEF];
  logic             tbl_deleted[POINTS_DEF];
  logic [1:0]       mdl_mode;
  logic [LVL_W-1:0] mdl_manual;
  logic [LVL_W-1:0] mdl_sched;
  logic [LVL_W-1:0] mdl_driven;
  logic             mdl_clock_ok;
  logic             drive_toggled;

  assign in_data = {3'b000, cur_item.f};
  assign in_kind = cur_item.kind;

  daily_schedule_level_interpolator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_kind),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void apply_drive(input logic [LVL_W-1:0] v);
    if (mdl_driven != v) begin
      mdl_driven    = v;
      drive_toggled = 1'b1;
    end
  endfunction

  function automatic logic table_has_active();
    for (int i = 0; i < POINTS_DEF; i++)
      if (!tbl_deleted[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [LVL_W-1:0] interpolate_at(input int unsigned minute);
    int unsigned pd = DAY_MINUTES, nd = DAY_MINUTES, cnt = 0, prv = 0, nxt = 0;
    int unsigned back, fwd;
    bit          has_prv = 0, has_nxt = 0;
    longint      delta, span, num, r;
    for (int i = 0; i < POINTS_DEF; i++) begin
      if (tbl_deleted[i]) continue;
      cnt++;
      back = (minute + DAY_MINUTES - tbl_minute[i]) % DAY_MINUTES;
      fwd  = (tbl_minute[i] + DAY_MINUTES - minute) % DAY_MINUTES;
      if (back < pd) begin
        pd = back; prv = i; has_prv = 1;
      end
      if (fwd < nd) begin
        nd = fwd; nxt = i; has_nxt = 1;
      end
    end
    if (cnt == 0 || !has_prv || !has_nxt) return '0;
    if (cnt == 1 || pd + nd == 0) return tbl_level[prv];
    delta = longint'(tbl_level[nxt]) - longint'(tbl_level[prv]);
    span  = longint'(pd + nd);
    num   = delta * longint'(pd);
    // round half away from zero
    num   = (num >= 0) ? num + span / 2 : num - span / 2;
    r     = longint'(tbl_level[prv]) + num / span;
    if (r < 0) r = 0;
    if (r > LEVEL_MAX_DEF) r = LEVEL_MAX_DEF;
    return r[LVL_W-1:0];
  endfunction

  function automatic void refresh_schedule(input logic [MIN_W-1:0] minute, input logic valid);
    mdl_clock_ok = valid && (minute < DAY_MINUTES);
    mdl_sched    = mdl_clock_ok ? interpolate_at(minute) : '0;
    if (!table_has_active()) mdl_sched = '0;
    apply_drive(mdl_sched);
  endfunction

  function automatic level_result_t predict_level(input pending_item_t it);
    level_result_t res;
    logic          ok;
    ok            = 1'b1;
    drive_toggled = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (mdl_mode == MODE_OFF) apply_drive('0);
        else if (mdl_mode == MODE_SCHED) refresh_schedule(it.f.minute, it.f.valid);
      end
      KIND_MODE: begin
        case (it.f.mode)
          MODE_OFF: begin
            mdl_mode = MODE_OFF;
            apply_drive('0);
          end
          MODE_MANUAL: begin
            mdl_manual = mdl_driven;
            mdl_mode   = MODE_MANUAL;
          end
          MODE_SCHED: begin
            mdl_mode = MODE_SCHED;
            refresh_schedule(it.f.minute, it.f.valid);
          end
          default: ok = 1'b0;
        endcase
      end
      KIND_MANUAL: begin
        if (it.f.level > LEVEL_MAX_DEF) begin
          ok = 1'b0;
        end else begin
          mdl_manual = it.f.level;
          mdl_mode   = MODE_MANUAL;
          apply_drive(mdl_manual);
        end
      end
      default: begin
        if (it.f.idx >= POINTS_DEF || it.f.pmin >= DAY_MINUTES || it.f.level > LEVEL_MAX_DEF) begin
          ok = 1'b0;
        end else begin
          tbl_minute[it.f.idx]  = it.f.pmin;
          tbl_level[it.f.idx]   = it.f.level;
          tbl_deleted[it.f.idx] = it.f.pdel;
          if (mdl_mode == MODE_SCHED) refresh_schedule(it.f.minute, it.f.valid);
        end
      end
    endcase
    res.accepted        = ok;
    res.drive_level     = mdl_driven;
    res.drive_changed   = drive_toggled;
    res.requested_level = (mdl_mode == MODE_OFF) ? '0 :
                          (mdl_mode == MODE_MANUAL) ? mdl_manual : mdl_sched;
    res.has_points      = table_has_active();
    res.clock_ok        = mdl_clock_ok;
    res.mode_now        = mdl_mode;
    return res;
  endfunction

  function automatic void queue_cmd(input logic [1:0] kind, input int unsigned minute,
                                    input bit valid, input logic [1:0] mode,
                                    input int unsigned level, input int unsigned idx,
                                    input int unsigned pmin, input bit pdel, input bit drain);
    pending_item_t it;
    it.drain    = drain;
    it.kind     = kind;
    it.f.minute = minute[MIN_W-1:0];
    it.f.valid  = valid;
    it.f.mode   = mode;
    it.f.level  = level[LVL_W-1:0];
    it.f.idx    = idx[2:0];
    it.f.pmin   = pmin[MIN_W-1:0];
    it.f.pdel   = pdel;
    cmd_queue.push_back(it);
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // outputs and input handshakes sampled at the rising edge
  always @(posedge clk_i) begin : check_side
    level_result_t got, want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got = out_data[37:0];
        if (level_expect.size() == 0) begin
          $error("unexpected result item 0x%0h", out_data);
          mismatches++;
        end else begin
          want = level_expect.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("drive_level", want.drive_level, got.drive_level);
          check_field("drive_changed", want.drive_changed, got.drive_changed);
          check_field("requested_level", want.requested_level, got.requested_level);
          check_field("has_points", want.has_points, got.has_points);
          check_field("clock_ok", want.clock_ok, got.clock_ok);
          check_field("mode_now", want.mode_now, got.mode_now);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) level_expect.push_back(predict_level(cur_item));
    end
  end

  // inputs change at the falling edge
  always @(negedge clk_i) begin : drive_side
    logic nxt_valid;
    if (rst_ni) begin
      if (sent_count * 3 < total_items) begin
        send_idle_pct = 19; recv_idle_pct = 47;
      end else if (sent_count * 3 < total_items * 2) begin
        send_idle_pct = 47; recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (!in_valid || in_taken) begin
        nxt_valid = 1'b0;
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!cmd_queue[0].drain || level_expect.size() == 0)) begin
          cur_item <= cmd_queue.pop_front();
          nxt_valid = 1'b1;
          sent_count++;
        end
        in_valid <= nxt_valid;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #15000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    int unsigned r, lvl;
    logic [1:0]  md;
    for (int i = 0; i < POINTS_DEF; i++) begin
      tbl_minute[i]  = '0;
      tbl_level[i]   = '0;
      tbl_deleted[i] = 1'b1;
    end
    mdl_mode      = MODE_OFF;
    mdl_manual    = '0;
    mdl_sched     = '0;
    mdl_driven    = '0;
    mdl_clock_ok  = 1'b0;
    drive_toggled = 1'b0;

    // directed: extremes, rejects, invalid clock, wrap, ties
    queue_cmd(KIND_TICK,   0,    1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_MANUAL, 0,    0, MODE_OFF,    1023,  0, 0,    0, 0);
    queue_cmd(KIND_TICK,   1439, 1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_MANUAL, 0,    0, MODE_OFF,    1024,  0, 0,    0, 0);
    queue_cmd(KIND_MANUAL, 2047, 1, 2'd3,        65535, 7, 2047, 1, 0);
    queue_cmd(KIND_MODE,   0,    0, 2'd3,        0,     0, 0,    0, 0);
    queue_cmd(KIND_MODE,   0,    0, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_MODE,   600,  1, MODE_SCHED,  0,     0, 0,    0, 0);
    queue_cmd(KIND_POINT,  600,  1, MODE_OFF,    1023,  0, 0,    0, 0);
    queue_cmd(KIND_POINT,  720,  1, MODE_OFF,    0,     7, 1439, 0, 1);
    queue_cmd(KIND_POINT,  720,  1, MODE_OFF,    5,     1, 1440, 0, 0);
    queue_cmd(KIND_POINT,  720,  1, MODE_OFF,    5,     1, 2047, 0, 0);
    queue_cmd(KIND_POINT,  720,  1, MODE_OFF,    1024,  1, 100,  0, 0);
    queue_cmd(KIND_POINT,  720,  1, MODE_OFF,    65535, 1, 100,  0, 0);
    queue_cmd(KIND_TICK,   720,  0, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_TICK,   2047, 1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_TICK,   1439, 1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_TICK,   0,    1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_POINT,  300,  1, MODE_OFF,    10,    3, 500,  0, 0);
    queue_cmd(KIND_POINT,  300,  1, MODE_OFF,    900,   4, 500,  0, 0);
    queue_cmd(KIND_TICK,   500,  1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_TICK,   1000, 1, MODE_OFF,    0,     0, 0,    0, 0);
    queue_cmd(KIND_MODE,   0,    0, MODE_MANUAL, 0,     0, 0,    0, 0);
    queue_cmd(KIND_POINT,  0,    0, MODE_OFF,    0,     7, 1439, 1, 0);
    queue_cmd(KIND_MANUAL, 0,    0, MODE_OFF,    0,     0, 0,    0, 0);

    // random: mostly scheduled operation with valid points and clock
    for (int n = 0; n < 1050; n++) begin
      r = $urandom_range(99);
      case ($urandom_range(9))
        0:       md = MODE_OFF;
        1:       md = MODE_MANUAL;
        2:       md = 2'd3;
        default: md = MODE_SCHED;
      endcase
      lvl = ($urandom_range(99) < 85) ? $urandom_range(LEVEL_MAX_DEF) : $urandom_range(65535);
      queue_cmd((r < 40) ? KIND_TICK : (r < 55) ? KIND_MODE : (r < 65) ? KIND_MANUAL : KIND_POINT,
                ($urandom_range(99) < 90) ? $urandom_range(DAY_MINUTES - 1) : $urandom_range(2047),
                ($urandom_range(99) < 92), md, lvl, $urandom_range(7),
                ($urandom_range(99) < 90) ? $urandom_range(DAY_MINUTES - 1) : $urandom_range(2047),
                ($urandom_range(99) < 20), (n % 150 == 149));
    end
    total_items = cmd_queue.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || in_valid || level_expect.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && level_expect.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dsli_pkg.sv
rtl/core/dsli_point_table.sv
rtl/core/dsli_divider.sv
rtl/core/daily_schedule_level_interpolator.sv
dv/tb_daily_schedule_level_interpolator.sv
